### hw/rtl/pab_pkg.sv
package pab_pkg;

  localparam int ChanW   = 8;
  localparam int CoefW   = 9;
  localparam int NumW    = 16;
  localparam int LumaW   = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgDatW = 9;

  localparam logic [CoefW-1:0] WeightMax = CoefW'(256);
  localparam logic [CoefW-1:0] AlphaMax  = CoefW'(255);

  localparam logic [ChanW-1:0] LumaCoefB = ChanW'(28);
  localparam logic [ChanW-1:0] LumaCoefG = ChanW'(151);
  localparam logic [ChanW-1:0] LumaCoefR = ChanW'(77);

  typedef enum logic [1:0] {
    MODE_CONST = 2'd0,
    MODE_ARGB  = 2'd1,
    MODE_RGB   = 2'd2,
    MODE_GRAY  = 2'd3
  } blend_mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE   = 1'b0,
    REG_WEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ChanW-1:0] base_alpha;
    logic [ChanW-1:0] base_red;
    logic [ChanW-1:0] base_green;
    logic [ChanW-1:0] base_blue;
    logic [ChanW-1:0] base_gray;
    logic [ChanW-1:0] over_alpha;
    logic [ChanW-1:0] over_red;
    logic [ChanW-1:0] over_green;
    logic [ChanW-1:0] over_blue;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] out_alpha;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_gray;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_wr_t;

endpackage

### hw/rtl/pab_chan_if.sv
interface pab_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/pixel_alpha_blender_top.sv
// Channel  Role   Payload                         Transaction
// in_chan  sink   pab_pkg::in_item_t  (9 bytes)   valid && ready at clk rise
// out_chan source pab_pkg::out_item_t (5 bytes)   valid && ready at clk rise
// cfg_chan sink   pab_pkg::cfg_wr_t (index, data) valid && ready, always ready
//
// One pixel per cycle sustained while the output register is not stalled.
// The path is an input register, a product stage (channel mixes and luma) and
// a result stage (luma weighting and the divide by 255 or by 256), then the output register.
// All three registers move together whenever the output register is empty or
// being taken, so a stalled result holds every stage in place.
// Reset clears the valid bits and sets mode 0 with weight 0.
module pixel_alpha_blender_top (
  input  logic clk,
  input  logic rst_n,
  pab_chan_if.sink   in_chan,
  pab_chan_if.source out_chan,
  pab_chan_if.sink   cfg_chan
);

  typedef struct packed {
    logic [pab_pkg::CoefW-1:0] coef_over;
    logic [pab_pkg::NumW-1:0]  num_alpha;
    logic [pab_pkg::NumW-1:0]  num_red;
    logic [pab_pkg::NumW-1:0]  num_green;
    logic [pab_pkg::NumW-1:0]  num_blue;
    logic [pab_pkg::NumW-1:0]  num_gray;
    logic [pab_pkg::LumaW-1:0] luma;
    logic [pab_pkg::ChanW-1:0] base_alpha;
  } prod_t;

  // floor(x / 255), exact for every x below 65280.
  function automatic logic [pab_pkg::ChanW-1:0] div255(input logic [pab_pkg::NumW-1:0] x);
    logic [pab_pkg::NumW:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [pab_pkg::NumW-1:0] mix_num(
    input logic [pab_pkg::CoefW-1:0] cb,
    input logic [pab_pkg::CoefW-1:0] co,
    input logic [pab_pkg::ChanW-1:0] p,
    input logic [pab_pkg::ChanW-1:0] q
  );
    logic [pab_pkg::CoefW+pab_pkg::ChanW-1:0] s;
    s = cb * p + co * q;
    return s[pab_pkg::NumW-1:0];
  endfunction

  pab_pkg::blend_mode_t      mode_r;
  logic [pab_pkg::CoefW-1:0] weight_r;

  logic                 adv;
  logic                 in_valid_r;
  pab_pkg::in_item_t    in_r;
  logic                 prod_valid_r;
  prod_t                prod_r, prod_nxt;
  logic                 out_valid_r;
  pab_pkg::out_item_t   out_r, out_nxt;

  assign adv            = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = adv;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= pab_pkg::MODE_CONST;
      weight_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.data.index)
        pab_pkg::REG_MODE:   mode_r   <= pab_pkg::blend_mode_t'(cfg_chan.data.data[1:0]);
        pab_pkg::REG_WEIGHT: weight_r <= cfg_chan.data.data;
        default: ;
      endcase
    end
  end

  // Product stage.
  always_comb begin
    logic [pab_pkg::CoefW-1:0] w_sat;
    logic [pab_pkg::CoefW-1:0] cb;
    logic [pab_pkg::CoefW-1:0] co;
    logic [17:0]               l_sum;
    w_sat = (weight_r > pab_pkg::WeightMax) ? pab_pkg::WeightMax : weight_r;
    if (mode_r == pab_pkg::MODE_CONST) begin
      cb = pab_pkg::WeightMax - w_sat;
      co = w_sat;
    end else begin
      co = {1'b0, in_r.over_alpha};
      cb = pab_pkg::AlphaMax - co;
    end
    l_sum = 18'(pab_pkg::LumaCoefB) * 18'(in_r.over_blue)
          + 18'(pab_pkg::LumaCoefG) * 18'(in_r.over_green)
          + 18'(pab_pkg::LumaCoefR) * 18'(in_r.over_red);
    prod_nxt.coef_over  = co;
    prod_nxt.num_alpha  = mix_num(cb, co, in_r.base_alpha, in_r.over_alpha);
    prod_nxt.num_red    = mix_num(cb, co, in_r.base_red, in_r.over_red);
    prod_nxt.num_green  = mix_num(cb, co, in_r.base_green, in_r.over_green);
    prod_nxt.num_blue   = mix_num(cb, co, in_r.base_blue, in_r.over_blue);
    prod_nxt.num_gray   = mix_num(cb, '0, in_r.base_gray, '0);
    prod_nxt.luma       = l_sum[pab_pkg::LumaW-1:0];
    prod_nxt.base_alpha = in_r.base_alpha;
  end

  // Result stage. The weighted luma is shifted down by 8 so the gray sum
  // shares the same divide as the color channels.
  always_comb begin
    logic [pab_pkg::CoefW+pab_pkg::LumaW-1:0] wl;
    logic [pab_pkg::NumW:0]                   g_sum;
    wl    = prod_r.coef_over * prod_r.luma;
    g_sum = {1'b0, prod_r.num_gray} + wl[pab_pkg::CoefW+pab_pkg::LumaW-1:8];
    out_nxt = '0;
    case (mode_r)
      pab_pkg::MODE_CONST: begin
        out_nxt.out_alpha = prod_r.num_alpha[15:8];
        out_nxt.out_red   = prod_r.num_red[15:8];
        out_nxt.out_green = prod_r.num_green[15:8];
        out_nxt.out_blue  = prod_r.num_blue[15:8];
        out_nxt.out_gray  = g_sum[15:8];
      end
      pab_pkg::MODE_ARGB, pab_pkg::MODE_RGB: begin
        out_nxt.out_alpha = (mode_r == pab_pkg::MODE_ARGB) ? prod_r.base_alpha : '0;
        out_nxt.out_red   = div255(prod_r.num_red);
        out_nxt.out_green = div255(prod_r.num_green);
        out_nxt.out_blue  = div255(prod_r.num_blue);
      end
      pab_pkg::MODE_GRAY: begin
        out_nxt.out_gray = div255(g_sum[pab_pkg::NumW-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (adv) begin
      in_valid_r   <= in_chan.valid;
      prod_valid_r <= in_valid_r;
      out_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r   <= in_chan.data;
      prod_r <= prod_nxt;
      out_r  <= out_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !prod_valid_r && !in_valid_r)
    else $error("pipeline not empty after reset");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> in_valid_r)
    else $error("accepted transaction not captured in input register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    prod_valid_r && !adv |=> prod_valid_r && $stable(prod_r))
    else $error("product stage changed during a stall");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(prod_valid_r))
    else $error("result appeared without a product stage entry");

endmodule

### bench/pab_blend_checker.sv
module pab_blend_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  pab_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  pab_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  pab_pkg::cfg_wr_t   cfg_data,
  output int                 error_count,
  output int                 pixels_in_flight
);

  pab_pkg::blend_mode_t        cur_mode;
  logic [pab_pkg::CfgDatW-1:0] cur_weight;
  pab_pkg::out_item_t          expected_pixels[$];
  pab_pkg::out_item_t          want;

  initial begin
    error_count = 0;
    pixels_in_flight = 0;
  end

  function automatic logic [pab_pkg::ChanW-1:0] mix_fixed(int unsigned p, int unsigned q,
                                                          int unsigned w);
    return pab_pkg::ChanW'(((256 - w) * p + w * q) >> 8);
  endfunction

  function automatic logic [pab_pkg::ChanW-1:0] mix_by_alpha(int unsigned p,
                                                             int unsigned q,
                                                             int unsigned a);
    return pab_pkg::ChanW'(((255 - a) * p + a * q) / 255);
  endfunction

  function automatic pab_pkg::out_item_t blend_pixel(pab_pkg::in_item_t px);
    int unsigned        w;
    int unsigned        a;
    int unsigned        g;
    int unsigned        luma;
    pab_pkg::out_item_t r;
    r = '0;
    // Weights above 256 clamp to overlay only.
    w = (cur_weight > 256) ? 256 : int'(cur_weight);
    a = px.over_alpha;
    g = px.base_gray;
    luma = int'(pab_pkg::LumaCoefB) * px.over_blue + int'(pab_pkg::LumaCoefG) * px.over_green
         + int'(pab_pkg::LumaCoefR) * px.over_red;
    case (cur_mode)
      pab_pkg::MODE_CONST: begin
        r.out_alpha = mix_fixed(px.base_alpha, px.over_alpha, w);
        r.out_red   = mix_fixed(px.base_red, px.over_red, w);
        r.out_green = mix_fixed(px.base_green, px.over_green, w);
        r.out_blue  = mix_fixed(px.base_blue, px.over_blue, w);
        // The overlay has no gray byte, so its luma stands in for it.
        r.out_gray  = pab_pkg::ChanW'(((256 - w) * 256 * g + w * luma) >> 16);
      end
      pab_pkg::MODE_ARGB, pab_pkg::MODE_RGB: begin
        r.out_alpha = (cur_mode == pab_pkg::MODE_ARGB) ? px.base_alpha : '0;
        r.out_red   = mix_by_alpha(px.base_red, px.over_red, a);
        r.out_green = mix_by_alpha(px.base_green, px.over_green, a);
        r.out_blue  = mix_by_alpha(px.base_blue, px.over_blue, a);
      end
      default: begin
        r.out_gray = pab_pkg::ChanW'(((255 - a) * 256 * g + a * luma) / 65280);
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [pab_pkg::ChanW-1:0] exp_val,
                             logic [pab_pkg::ChanW-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode = pab_pkg::MODE_CONST;
      cur_weight = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_data.index == pab_pkg::REG_MODE) begin
          cur_mode = pab_pkg::blend_mode_t'(cfg_data.data[1:0]);
        end else begin
          cur_weight = cfg_data.data;
        end
      end
      if (in_valid && in_ready) begin
        expected_pixels.push_back(blend_pixel(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with no pixel pending");
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_alpha", want.out_alpha, out_data.out_alpha);
          check_field("out_red", want.out_red, out_data.out_red);
          check_field("out_green", want.out_green, out_data.out_green);
          check_field("out_blue", want.out_blue, out_data.out_blue);
          check_field("out_gray", want.out_gray, out_data.out_gray);
        end
      end
    end
    pixels_in_flight = expected_pixels.size();
  end

endmodule

### bench/tb_pixel_alpha_blender_top.sv
module tb_pixel_alpha_blender_top;

  localparam int CycleLimit     = 200000;
  localparam int PhaseCount     = 12;
  localparam int DirectedPhases = 8;
  localparam int RandomPerPhase = 96;
  localparam int SettleCycles   = 8;

  logic clk;
  logic rst_n;
  bit   idle_enable;
  int   cycle_count;
  int   error_count;
  int   pixels_in_flight;

  pab_pkg::blend_mode_t phase_mode[PhaseCount] = '{
    pab_pkg::MODE_CONST, pab_pkg::MODE_CONST, pab_pkg::MODE_CONST, pab_pkg::MODE_CONST,
    pab_pkg::MODE_ARGB, pab_pkg::MODE_RGB, pab_pkg::MODE_GRAY, pab_pkg::MODE_CONST,
    pab_pkg::MODE_ARGB, pab_pkg::MODE_GRAY, pab_pkg::MODE_RGB, pab_pkg::MODE_CONST
  };
  logic [pab_pkg::CfgDatW-1:0] phase_weight[PhaseCount] = '{
    0, 256, 511, 128, 17, 255, 300, 257, 0, 64, 511, 1
  };

  pab_chan_if #(.T(pab_pkg::in_item_t))  in_chan ();
  pab_chan_if #(.T(pab_pkg::out_item_t)) out_chan ();
  pab_chan_if #(.T(pab_pkg::cfg_wr_t))   cfg_chan ();

  pixel_alpha_blender_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  pab_blend_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_chan.valid),
    .in_ready         (in_chan.ready),
    .in_data          (in_chan.data),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_data         (out_chan.data),
    .cfg_valid        (cfg_chan.valid),
    .cfg_ready        (cfg_chan.ready),
    .cfg_data         (cfg_chan.data),
    .error_count      (error_count),
    .pixels_in_flight (pixels_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [pab_pkg::ChanW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return pab_pkg::ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pab_pkg::in_item_t random_pixel();
    pab_pkg::in_item_t px;
    px.base_alpha = pick_byte();
    px.base_red   = pick_byte();
    px.base_green = pick_byte();
    px.base_blue  = pick_byte();
    px.base_gray  = pick_byte();
    px.over_alpha = pick_byte();
    px.over_red   = pick_byte();
    px.over_green = pick_byte();
    px.over_blue  = pick_byte();
    return px;
  endfunction

  // Opaque base under a clear overlay, clear base under an opaque overlay,
  // and a half-transparent overlay on alternating bit patterns.
  function automatic pab_pkg::in_item_t directed_pixel(int k);
    pab_pkg::in_item_t px;
    case (k)
      0: px = {{5{8'hFF}}, {4{8'h00}}};
      1: px = {{5{8'h00}}, {4{8'hFF}}};
      default: px = {{5{8'hAA}}, 8'h80, {3{8'h55}}};
    endcase
    return px;
  endfunction

  task automatic drive_pixel(pab_pkg::in_item_t px);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= px;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops the pixel stream and waits until every pending result has come out.
  task automatic drain_pixels();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pixels_in_flight != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(pab_pkg::cfg_reg_t idx, logic [pab_pkg::CfgDatW-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= pab_pkg::cfg_wr_t'{index: idx, data: value};
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    rst_n          = 1'b0;
    idle_enable    = 1'b1;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < PhaseCount; p++) begin
      // The first phase runs on the reset settings.
      if (p > 0) begin
        write_reg(pab_pkg::REG_MODE,
                  {pab_pkg::CfgDatW'($urandom_range(0, 127)) << 2}
                  | pab_pkg::CfgDatW'(phase_mode[p]));
        write_reg(pab_pkg::REG_WEIGHT, phase_weight[p]);
      end
      if (p == PhaseCount - 1) begin
        idle_enable = 1'b0;
      end
      if (p < DirectedPhases) begin
        for (int k = 0; k < 3; k++) begin
          drive_pixel(directed_pixel(k));
        end
      end
      for (int i = 0; i < RandomPerPhase; i++) begin
        if (p == 3 && i == RandomPerPhase / 2) begin
          drain_pixels();
        end
        drive_pixel(random_pixel());
      end
      drain_pixels();
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
